// ----- rtl/spct_pkg.sv -----
// constants shared by the sphere pair collision test core
// no dependencies
`default_nettype none
package spct_pkg;
   localparam int FRAC_BITS = 16;
   localparam int NORM_W = 32;
   localparam int NORM_FRAC = 30;
   localparam int DIV_STEPS = 31;
   localparam int DEPTH_SHIFT = 46;
   localparam int LEN_SPLIT = 24;
   localparam int QUEUE_DEPTH = 4;
   localparam logic [NORM_W-2:0] NORM_MAX = {(NORM_W-1){1'b1}};
   localparam logic [NORM_W-2:0] NORM_ONE = (NORM_W-1)'(1) << NORM_FRAC;
endpackage
`default_nettype wire

// ----- rtl/spct_front.sv -----
// front stage: centre deltas, squared distance, overlap classification
// depends on spct_pkg
`default_nettype none
module spct_front #(
   parameter int W = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [W-1:0]        a_x,
   input  logic [W-1:0]        a_y,
   input  logic [W-1:0]        a_z,
   input  logic [W-2:0]        r_a,
   input  logic [W-1:0]        b_x,
   input  logic [W-1:0]        b_y,
   input  logic [W-1:0]        b_z,
   input  logic [W-2:0]        r_b,
   output logic                push,
   input  logic                q_full,
   output logic [10*W+8:0]     push_data
);
   import spct_pkg::*;

   localparam int MW = W + 1;
   localparam int DW = 2*W + 2;

   logic [W-1:0]    a_in [0:2];
   logic [W-1:0]    b_in [0:2];
   logic [MW-1:0]   d_in [0:2];
   logic [MW-1:0]   m_in [0:2];
   logic [2:0]      neg_in;
   logic [DW-1:0]   sq_in [0:2];
   logic [W-1:0]    s_in;
   logic [2*W-1:0]  s2_in;

   logic            v_ff;
   logic [W-1:0]    a_ff [0:2];
   logic [MW-1:0]   m_ff [0:2];
   logic [2:0]      neg_ff;
   logic [DW-1:0]   sq_ff [0:2];
   logic [W-2:0]    ra_ff;
   logic [W-1:0]    s_ff;
   logic [2*W-1:0]  s2_ff;

   logic [DW-1:0]   d2;
   logic            hit;
   logic            zero;
   logic            load;

   assign a_in[0] = a_x;
   assign a_in[1] = a_y;
   assign a_in[2] = a_z;
   assign b_in[0] = b_x;
   assign b_in[1] = b_y;
   assign b_in[2] = b_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_in[i] = {b_in[i][W-1], b_in[i]} - {a_in[i][W-1], a_in[i]};
         neg_in[i] = d_in[i][MW-1];
         m_in[i] = neg_in[i] ? (MW'(0) - d_in[i]) : d_in[i];
         sq_in[i] = {{(DW-MW){1'b0}}, m_in[i]} * {{(DW-MW){1'b0}}, m_in[i]};
      end
      s_in = {1'b0, r_a} + {1'b0, r_b};
      s2_in = {{W{1'b0}}, s_in} * {{W{1'b0}}, s_in};
   end

   assign push = v_ff && !q_full;
   assign in_ready = !v_ff || !q_full;
   assign load = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < 3; i++) begin
            a_ff[i] <= a_in[i];
            m_ff[i] <= m_in[i];
            sq_ff[i] <= sq_in[i];
         end
         neg_ff <= neg_in;
         ra_ff <= r_a;
         s_ff <= s_in;
         s2_ff <= s2_in;
      end
   end

   // overlap when squared distance is below squared radius sum
   assign d2 = sq_ff[0] + sq_ff[1] + sq_ff[2];
   assign hit = d2 < {2'b00, s2_ff};
   assign zero = d2 == '0;

   assign push_data = {d2, zero, hit, neg_ff, m_ff[2], m_ff[1], m_ff[0], s_ff, ra_ff,
                       a_ff[2], a_ff[1], a_ff[0]};
endmodule
`default_nettype wire

// ----- rtl/spct_queue.sv -----
// short register queue between the front and the back pipeline
// depends on spct_pkg
`default_nettype none
module spct_queue #(
   parameter int DATA_W = 329
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              avail,
   output logic [DATA_W-1:0] pop_data
);
   import spct_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [0:QUEUE_DEPTH-1];
   logic [PW-1:0]     wr_ff;
   logic [PW-1:0]     rd_ff;
   logic [CW-1:0]     cnt_ff;

   assign full = cnt_ff == CW'(QUEUE_DEPTH);
   assign avail = cnt_ff != '0;
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= PW'(wr_ff + 1'b1);
         if (pop) rd_ff <= PW'(rd_ff + 1'b1);
         if (push && !pop) cnt_ff <= CW'(cnt_ff + 1'b1);
         else if (pop && !push) cnt_ff <= CW'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end
endmodule
`default_nettype wire

// ----- rtl/spct_back.sv -----
// back pipeline: square root, normal division, contact and depth products
// depends on spct_pkg
`default_nettype none
module spct_back #(
   parameter int W = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_avail,
   input  logic [10*W+8:0]                 q_data,
   output logic                            q_pop,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic                            out_hit,
   output logic [W-1:0]                    out_contact [0:2],
   output logic [spct_pkg::NORM_W-1:0]     out_normal [0:2],
   output logic [W-1:0]                    out_depth [0:2]
);
   import spct_pkg::*;

   localparam int MW = W + 1;
   localparam int DW = 2*W + 2;
   localparam int SN = W + 17;
   localparam int XW = 2*SN;
   localparam int RW = SN + 2;
   localparam int LW = W + 16;
   localparam int DRW = SN + 1;
   localparam int QN = NORM_W - 1;
   localparam int OFW = W - 1 + QN;
   localparam int HW = LW - LEN_SPLIT;
   localparam int PLW = LEN_SPLIT + QN;
   localparam int PHW = HW + QN;
   localparam int FW = LW + QN;

   typedef struct packed {
      logic [3*W-1:0]  a;
      logic [W-2:0]    ra;
      logic [W-1:0]    s;
      logic [3*MW-1:0] m;
      logic [2:0]      neg;
      logic            hit;
      logic            zero;
   } sq_carry_type;

   typedef struct packed {
      logic [3*W-1:0]  a;
      logic [W-2:0]    ra;
      logic [LW-1:0]   len;
      logic [2:0]      neg;
      logic            hit;
      logic            zero;
   } dv_carry_type;

   function automatic logic [W-1:0] sat(input logic [W+1:0] v);
      if (v[W+1:W-1] == 3'b000 || v[W+1:W-1] == 3'b111) return v[W-1:0];
      else if (v[W+1]) return {1'b1, {(W-1){1'b0}}};
      else return {1'b0, {(W-1){1'b1}}};
   endfunction

   logic adv;
   assign adv = !out_valid || out_ready;
   assign q_pop = adv && q_avail;

   // unpack queue entry
   sq_carry_type    q_c;
   logic [DW-1:0]   q_d2;
   always_comb begin
      q_c.a    = q_data[3*W-1:0];
      q_c.ra   = q_data[4*W-2:3*W];
      q_c.s    = q_data[5*W-2:4*W-1];
      q_c.m    = q_data[8*W+1:5*W-1];
      q_c.neg  = q_data[8*W+4:8*W+2];
      q_c.hit  = q_data[8*W+5];
      q_c.zero = q_data[8*W+6];
      q_d2     = q_data[10*W+8:8*W+7];
   end

   // square root, one result bit per stage
   logic            sv_ff [0:SN];
   sq_carry_type    sc_ff [0:SN];
   logic [XW-1:0]   sx_ff [0:SN];
   logic [RW-1:0]   srem_ff [0:SN];
   logic [SN-1:0]   sroot_ff [0:SN];
   logic [RW-1:0]   st_t [0:SN-1];
   logic [RW-1:0]   trial [0:SN-1];
   logic            sge [0:SN-1];
   logic [RW-1:0]   srem_in [0:SN-1];
   logic [SN-1:0]   sroot_in [0:SN-1];

   always_comb begin
      for (int k = 0; k < SN; k++) begin
         st_t[k] = {srem_ff[k][RW-3:0], sx_ff[k][XW-1:XW-2]};
         trial[k] = {sroot_ff[k], 2'b01};
         sge[k] = st_t[k] >= trial[k];
         srem_in[k] = sge[k] ? (st_t[k] - trial[k]) : st_t[k];
         sroot_in[k] = {sroot_ff[k][SN-2:0], sge[k]};
      end
   end

   // restoring division for each normal component
   logic            dv_ff [0:DIV_STEPS];
   dv_carry_type    dc_ff [0:DIV_STEPS];
   logic [SN-1:0]   dl_ff [0:DIV_STEPS];
   logic [DRW-1:0]  drem_ff [0:DIV_STEPS][0:2];
   logic [QN-1:0]   dq_ff [0:DIV_STEPS][0:2];
   logic [2:0]      dovf_ff [0:DIV_STEPS];
   logic [DRW-1:0]  dt_t [0:DIV_STEPS-1][0:2];
   logic            dge [0:DIV_STEPS-1][0:2];
   logic [DRW-1:0]  drem_in [0:DIV_STEPS-1][0:2];
   logic [QN-1:0]   dq_in [0:DIV_STEPS-1][0:2];

   always_comb begin
      for (int k = 0; k < DIV_STEPS; k++) begin
         for (int i = 0; i < 3; i++) begin
            dt_t[k][i] = {drem_ff[k][i][DRW-2:0], 1'b0};
            dge[k][i] = dt_t[k][i] >= {1'b0, dl_ff[k]};
            drem_in[k][i] = dge[k][i] ? (dt_t[k][i] - {1'b0, dl_ff[k]}) : dt_t[k][i];
            dq_in[k][i] = {dq_ff[k][i][QN-2:0], dge[k][i]};
         end
      end
   end

   dv_carry_type    d0_c;
   logic [SN-1:0]   d0_lenw;
   logic [DRW-1:0]  d0_rem [0:2];
   logic [2:0]      d0_ovf;
   logic [MW-1:0]   d0_m [0:2];

   always_comb begin
      d0_lenw = {1'b0, sc_ff[SN].s, 16'b0} - sroot_ff[SN];
      d0_c.a = sc_ff[SN].a;
      d0_c.ra = sc_ff[SN].ra;
      d0_c.len = d0_lenw[LW-1:0];
      d0_c.neg = sc_ff[SN].neg;
      d0_c.hit = sc_ff[SN].hit;
      d0_c.zero = sc_ff[SN].zero;
      for (int i = 0; i < 3; i++) begin
         d0_m[i] = sc_ff[SN].m[i*MW +: MW];
         d0_rem[i] = {2'b00, d0_m[i], 15'b0};
         d0_ovf[i] = {1'b0, d0_m[i], 15'b0} >= sroot_ff[SN];
      end
   end

   // products
   logic            mv_ff;
   logic            mhit_ff;
   logic [W-1:0]    ma_ff [0:2];
   logic [2:0]      mneg_ff;
   logic [OFW-1:0]  moff_ff [0:2];
   logic [PLW-1:0]  mplo_ff [0:2];
   logic [PHW-1:0]  mphi_ff [0:2];
   logic [NORM_W-1:0] mn_ff [0:2];
   logic [QN-1:0]   nm [0:2];
   logic [2:0]      nneg;
   dv_carry_type    dl_c;

   always_comb begin
      dl_c = dc_ff[DIV_STEPS];
      for (int i = 0; i < 3; i++) begin
         if (dl_c.zero) nm[i] = (i == 1) ? NORM_ONE : '0;
         else if (dovf_ff[DIV_STEPS][i]) nm[i] = NORM_MAX;
         else nm[i] = dq_ff[DIV_STEPS][i];
         nneg[i] = dl_c.neg[i] && !dl_c.zero;
      end
   end

   // final adds and saturation
   logic [W-1:0]    off [0:2];
   logic [W+1:0]    csum [0:2];
   logic [FW-1:0]   full_p [0:2];
   logic [W:0]      dep [0:2];
   logic [W+1:0]    dsum [0:2];
   logic [W+1:0]    sa [0:2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         off[i] = moff_ff[i][OFW-1:NORM_FRAC];
         sa[i] = {{2{ma_ff[i][W-1]}}, ma_ff[i]};
         csum[i] = mneg_ff[i] ? (sa[i] - {2'b00, off[i]}) : (sa[i] + {2'b00, off[i]});
         full_p[i] = {mphi_ff[i], {LEN_SPLIT{1'b0}}} + {{(FW-PLW){1'b0}}, mplo_ff[i]};
         dep[i] = full_p[i][FW-1:DEPTH_SHIFT];
         dsum[i] = mneg_ff[i] ? ((W+2)'(0) - {1'b0, dep[i]}) : {1'b0, dep[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= SN; k++) sv_ff[k] <= 1'b0;
         for (int k = 0; k <= DIV_STEPS; k++) dv_ff[k] <= 1'b0;
         mv_ff <= 1'b0;
         out_valid <= 1'b0;
      end else if (adv) begin
         sv_ff[0] <= q_avail;
         for (int k = 0; k < SN; k++) sv_ff[k+1] <= sv_ff[k];
         dv_ff[0] <= sv_ff[SN];
         for (int k = 0; k < DIV_STEPS; k++) dv_ff[k+1] <= dv_ff[k];
         mv_ff <= dv_ff[DIV_STEPS];
         out_valid <= mv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sc_ff[0] <= q_c;
         sx_ff[0] <= {q_d2, 32'b0};
         srem_ff[0] <= '0;
         sroot_ff[0] <= '0;
         for (int k = 0; k < SN; k++) begin
            sc_ff[k+1] <= sc_ff[k];
            sx_ff[k+1] <= {sx_ff[k][XW-3:0], 2'b00};
            srem_ff[k+1] <= srem_in[k];
            sroot_ff[k+1] <= sroot_in[k];
         end

         dc_ff[0] <= d0_c;
         dl_ff[0] <= sroot_ff[SN];
         dovf_ff[0] <= d0_ovf;
         for (int i = 0; i < 3; i++) begin
            drem_ff[0][i] <= d0_rem[i];
            dq_ff[0][i] <= '0;
         end
         for (int k = 0; k < DIV_STEPS; k++) begin
            dc_ff[k+1] <= dc_ff[k];
            dl_ff[k+1] <= dl_ff[k];
            dovf_ff[k+1] <= dovf_ff[k];
            for (int i = 0; i < 3; i++) begin
               drem_ff[k+1][i] <= drem_in[k][i];
               dq_ff[k+1][i] <= dq_in[k][i];
            end
         end

         mhit_ff <= dl_c.hit;
         mneg_ff <= nneg;
         for (int i = 0; i < 3; i++) begin
            ma_ff[i] <= dl_c.a[i*W +: W];
            moff_ff[i] <= {{QN{1'b0}}, dl_c.ra} * {{(W-1){1'b0}}, nm[i]};
            mplo_ff[i] <= {{QN{1'b0}}, dl_c.len[LEN_SPLIT-1:0]} *
                          {{LEN_SPLIT{1'b0}}, nm[i]};
            mphi_ff[i] <= {{QN{1'b0}}, dl_c.len[LW-1:LEN_SPLIT]} * {{HW{1'b0}}, nm[i]};
            mn_ff[i] <= nneg[i] ? (NORM_W'(0) - {1'b0, nm[i]}) : {1'b0, nm[i]};
         end

         out_hit <= mhit_ff;
         for (int i = 0; i < 3; i++) begin
            out_contact[i] <= mhit_ff ? sat(csum[i]) : '0;
            out_normal[i] <= mhit_ff ? mn_ff[i] : '0;
            out_depth[i] <= mhit_ff ? sat(dsum[i]) : '0;
         end
      end
   end
endmodule
`default_nettype wire

// ----- rtl/sphere_pair_collision_test_core.sv -----
// sphere pair collision test: fully pipelined, one pair per cycle sustained
// while rsp_tready is high; latency from req transaction to rsp valid is set
// by the bit-per-stage square root and the 31-stage normal division
// synchronous active-high reset clears all valid flags and the queue
// depends on spct_pkg, spct_front, spct_queue, spct_back
`default_nettype none
module sphere_pair_collision_test_core #(
   parameter int COORD_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // a_x, a_y, a_z, radius_a, b_x, b_y, b_z, radius_b, zero pad
   input  logic [((8*COORD_WIDTH-2+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // contact x/y/z, normal x/y/z, depth x/y/z, zero pad
   output logic [((6*COORD_WIDTH+3*spct_pkg::NORM_W+7)/8)*8-1:0] rsp_tdata,
   // hit
   output logic rsp_tuser
);
   import spct_pkg::*;

   localparam int W = COORD_WIDTH;
   localparam int QW = 10*W + 9;
   localparam int OW = ((6*W + 3*NORM_W + 7)/8)*8;
   localparam int OPAD = OW - (6*W + 3*NORM_W);

   logic          push;
   logic          q_full;
   logic [QW-1:0] push_data;
   logic          q_pop;
   logic          q_avail;
   logic [QW-1:0] q_data;
   logic [W-1:0]  contact [0:2];
   logic [NORM_W-1:0] normal [0:2];
   logic [W-1:0]  depth [0:2];

   spct_front #(.W(W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .a_x       (req_tdata[W-1:0]),
      .a_y       (req_tdata[2*W-1:W]),
      .a_z       (req_tdata[3*W-1:2*W]),
      .r_a       (req_tdata[4*W-2:3*W]),
      .b_x       (req_tdata[5*W-2:4*W-1]),
      .b_y       (req_tdata[6*W-2:5*W-1]),
      .b_z       (req_tdata[7*W-2:6*W-1]),
      .r_b       (req_tdata[8*W-3:7*W-1]),
      .push      (push),
      .q_full    (q_full),
      .push_data (push_data)
   );

   spct_queue #(.DATA_W(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .avail     (q_avail),
      .pop_data  (q_data)
   );

   spct_back #(.W(W)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_avail     (q_avail),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_hit     (rsp_tuser),
      .out_contact (contact),
      .out_normal  (normal),
      .out_depth   (depth)
   );

   generate
      if (OPAD > 0) begin : g_pad
         assign rsp_tdata = {{OPAD{1'b0}}, depth[2], depth[1], depth[0],
                             normal[2], normal[1], normal[0],
                             contact[2], contact[1], contact[0]};
      end else begin : g_nopad
         assign rsp_tdata = {depth[2], depth[1], depth[0],
                             normal[2], normal[1], normal[0],
                             contact[2], contact[1], contact[0]};
      end
   endgenerate
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// testbench for sphere_pair_collision_test_core: directed and random sphere pairs
// expected hit, contact, normal and depth come from an exact integer predictor
// depends on spct_pkg and the core rtl
`default_nettype none

typedef struct {
   logic        hit;
   logic [31:0] contact [3];
   logic [31:0] normal [3];
   logic [31:0] depth [3];
} collision_type;

class collision_scoreboard;
   collision_type expected_q[$];
   int errors = 0;

   function logic [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFFFFFF;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function void note_request(logic [255:0] d);
      longint a[3], b[3], dd[3], n[3], off, dep;
      logic [127:0] d2, s, ra, rb, x, c, r, root_len, len, nm, q, mg [3];
      collision_type e;
      int i, k;
      d2 = 0;
      for (i = 0; i < 3; i++) begin
         a[i] = longint'($signed(d[32*i +: 32]));
         b[i] = longint'($signed(d[127+32*i +: 32]));
         dd[i] = b[i] - a[i];
         mg[i] = 128'(dd[i] < 0 ? -dd[i] : dd[i]);
         d2 = d2 + mg[i] * mg[i];
      end
      ra = 128'(d[126:96]);
      rb = 128'(d[253:223]);
      s = ra + rb;
      e.hit = 0;
      for (i = 0; i < 3; i++) begin
         e.contact[i] = 0; e.normal[i] = 0; e.depth[i] = 0;
      end
      if (d2 < s * s) begin
         e.hit = 1;
         if (d2 == 0) begin
            n[0] = 0; n[1] = 64'sd1 << 30; n[2] = 0;
            root_len = 0;
         end else begin
            x = d2 << 32;
            r = 0;
            for (k = 63; k >= 0; k--) begin
               c = r | (128'd1 << k);
               if (!(x < c * c)) r = c;
            end
            root_len = r;
            for (i = 0; i < 3; i++) begin
               q = (mg[i] << 46) / root_len;
               if (q > 128'h7FFFFFFF) q = 128'h7FFFFFFF;
               n[i] = dd[i] < 0 ? -longint'(q) : longint'(q);
            end
         end
         len = (s << 16) - root_len;
         for (i = 0; i < 3; i++) begin
            nm = 128'(n[i] < 0 ? -n[i] : n[i]);
            off = longint'((ra * nm) >> 30);
            dep = longint'((len * nm) >> 46);
            if (n[i] < 0) begin
               off = -off; dep = -dep;
            end
            e.contact[i] = sat32(a[i] + off);
            e.normal[i] = n[i][31:0];
            e.depth[i] = sat32(dep);
         end
      end
      expected_q.insert(expected_q.size(), e);
   endfunction

   function void check_response(logic [287:0] td, logic hit);
      collision_type e;
      int i;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result hit=%0b data=%h", $time, hit, td);
         errors++;
         return;
      end
      e = expected_q.pop_front();
      if (hit !== e.hit) begin
         $display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
         errors++;
      end
      for (i = 0; i < 3; i++) begin
         if (td[32*i +: 32] !== e.contact[i]) begin
            $display("%0t: contact[%0d] expected %h actual %h", $time, i, e.contact[i],
                     td[32*i +: 32]);
            errors++;
         end
         if (td[96+32*i +: 32] !== e.normal[i]) begin
            $display("%0t: normal[%0d] expected %h actual %h", $time, i, e.normal[i],
                     td[96+32*i +: 32]);
            errors++;
         end
         if (td[192+32*i +: 32] !== e.depth[i]) begin
            $display("%0t: depth[%0d] expected %h actual %h", $time, i, e.depth[i],
                     td[192+32*i +: 32]);
            errors++;
         end
      end
   endfunction
endclass

module tb;
   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [255:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [287:0] rsp_tdata;
   logic rsp_tuser;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   longint cycle_count = 0;
   collision_scoreboard sb = new();

   sphere_pair_collision_test_core #(.COORD_WIDTH(32)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (!reset && req_tvalid && req_tready) sb.note_request(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [255:0] pack_pair(logic [31:0] ax, logic [31:0] ay,
         logic [31:0] az, logic [30:0] ra, logic [31:0] bx, logic [31:0] by,
         logic [31:0] bz, logic [30:0] rb);
      return {2'b00, rb, bz, by, bx, ra, az, ay, ax};
   endfunction

   task automatic send_pair(logic [255:0] d);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random_pair();
      logic [31:0] a [3], b [3];
      logic [30:0] ra, rb;
      int i;
      if ($urandom_range(0, 99) < 75) begin
         for (i = 0; i < 3; i++) begin
            a[i] = $signed($urandom) >>> $urandom_range(0, 20);
            b[i] = 32'($signed(a[i]) + ($signed($urandom) >>> $urandom_range(4, 31)));
         end
         ra = 31'($urandom) >> $urandom_range(3, 30);
         rb = 31'($urandom) >> $urandom_range(3, 30);
      end else begin
         for (i = 0; i < 3; i++) begin
            a[i] = $urandom;
            b[i] = $urandom;
         end
         ra = 31'($urandom);
         rb = 31'($urandom);
      end
      send_pair(pack_pair(a[0], a[1], a[2], ra, b[0], b[1], b[2], rb));
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   localparam logic [31:0] MAXC = 32'h7FFFFFFF;
   localparam logic [31:0] MINC = 32'h80000000;
   localparam logic [30:0] MAXR = 31'h7FFFFFFF;
   localparam logic [31:0] ONE = 32'h00010000;

   initial begin
      int p, k;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // coincident centres, zero radii, touching, extremes
      send_pair(pack_pair(0, 0, 0, 31'h10000, 0, 0, 0, 31'h10000));
      send_pair(pack_pair(ONE, 5, -7, 0, ONE, 5, -7, 31'h1));
      send_pair(pack_pair(0, 0, 0, 0, 0, 0, 0, 0));
      send_pair(pack_pair(5, 5, 5, 0, 5, 5, 5, 0));
      send_pair(pack_pair(0, 0, 0, 31'h10000, 32'h20000, 0, 0, 31'h10000));
      send_pair(pack_pair(0, 0, 0, 31'h10000, 32'h1FFFF, 0, 0, 31'h10000));
      send_pair(pack_pair(MAXC, MAXC, MAXC, MAXR, MAXC, MAXC, MAXC, MAXR));
      send_pair(pack_pair(MINC, MINC, MINC, MAXR, MINC, MINC, MINC, MAXR));
      send_pair(pack_pair(MINC, MINC, MINC, MAXR, MAXC, MAXC, MAXC, MAXR));
      send_pair(pack_pair(MAXC, MINC, 0, MAXR, MINC, MAXC, 0, MAXR));
      send_pair(pack_pair(MINC, 0, 0, MAXR, MAXC, 0, 0, MAXR));
      send_pair(pack_pair(0, MAXC, 0, MAXR, 0, MINC, 0, 0));
      send_pair(pack_pair(0, 0, MAXC, 31'h1, 0, 0, MINC, 31'h1));
      send_pair(pack_pair(ONE, ONE, ONE, 31'h30000, -ONE, -ONE, -ONE, 31'h30000));
      send_pair(pack_pair(0, 0, 0, 31'h8000, 1, 0, 0, 0));
      send_pair(pack_pair(0, 0, 0, MAXR, 0, 0, 1, MAXR));
      send_pair(pack_pair(MAXC, 0, 0, MAXR, MAXC - 1, 0, 0, 0));
      send_pair(pack_pair(MINC, 0, 0, MAXR, MINC + 1, 0, 0, 0));
      drain();

      for (p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 25 : (p == 1) ? 79 : 0;
         recv_idle_pct = (p == 0) ? 79 : (p == 1) ? 25 : 0;
         for (k = 0; k < 380; k++) send_random_pair();
         drain();
      end
      recv_idle_pct = 0;

      repeat (120) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ----- files.f -----
rtl/spct_pkg.sv
rtl/spct_front.sv
rtl/spct_queue.sv
rtl/spct_back.sv
rtl/sphere_pair_collision_test_core.sv
tb/tb.sv
